// ===== src/lkc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkc_pkg: shared definitions for the keyed LRU cache
// Sizes, request codes, sequencer states and the entry unit interface types.
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam int ENTRIES   = 128;
    localparam int KEY_BITS  = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int CAP_W     = 8;
    localparam int KEY_W     = 64;
    localparam int PAYLOAD_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef enum logic {
        UPD_TOUCH,
        UPD_AGE
    } upd_mode_t;

    // One stored entry as presented to the entry unit
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] tag;
        logic [IDX_W-1:0]    rank;
        logic [IDX_W-1:0]    idx;
    } ent_in_t;

    // Per-request controls for the entry unit
    typedef struct packed {
        upd_mode_t           mode;
        logic                evict_en;
        logic [IDX_W-1:0]    hit_idx;
        logic [IDX_W-1:0]    hit_rank;
        logic [CNT_W-1:0]    cap;
        logic [KEY_BITS-1:0] key;
    } ent_ctl_t;

    typedef struct packed {
        logic             match;
        logic             oldest;
        logic             evict;
        logic             evkey_take;
        logic [CNT_W-1:0] new_rank;
    } ent_res_t;

    // Clamp the capacity register to 1..ENTRIES
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        if (w == 32'd0) w = 32'd1;
        if (w > 32'(ENTRIES)) w = 32'(ENTRIES);
        return CNT_W'(w);
    endfunction

endpackage

// ===== src/lkc_ram.sv =====
// ----------------------------------------------------------------------------
// lkc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lkc_entry_unit.sv =====
// ----------------------------------------------------------------------------
// lkc_entry_unit: shared per-entry compare and rank update
// Tag match, oldest detection, new recency rank and eviction decision for
// the one entry the sequencer presents in a cycle.
// ----------------------------------------------------------------------------
module lkc_entry_unit (
    input  lkc_pkg::ent_in_t  ent,
    input  lkc_pkg::ent_ctl_t ctl,
    output lkc_pkg::ent_res_t res
);

    logic [lkc_pkg::CNT_W-1:0] rank_w;
    logic [lkc_pkg::CNT_W-1:0] nr;

    always_comb begin
        rank_w = lkc_pkg::CNT_W'(ent.rank);
        case (ctl.mode)
            lkc_pkg::UPD_TOUCH: begin
                if (ent.idx == ctl.hit_idx) begin
                    nr = '0;
                end else if (ent.rank < ctl.hit_rank) begin
                    nr = rank_w + 1'b1;
                end else begin
                    nr = rank_w;
                end
            end
            lkc_pkg::UPD_AGE: begin
                nr = rank_w + 1'b1;
            end
            default: begin
                nr = rank_w;
            end
        endcase

        res.match      = ent.valid && (ent.tag == ctl.key);
        res.oldest     = ent.valid && (ent.rank == lkc_pkg::IDX_W'(lkc_pkg::ENTRIES - 1));
        res.new_rank   = nr;
        // entries pushed at or past capacity drop out; the one landing on
        // capacity is the last one the model would evict
        res.evict      = ctl.evict_en && (nr >= ctl.cap);
        res.evkey_take = ctl.evict_en && (nr == ctl.cap);
    end

endmodule

// ===== src/lru_keyed_cache.sv =====
// ----------------------------------------------------------------------------
// lru_keyed_cache: fully associative LRU cache of key/payload pairs
// Sequential tag scan and, for hits and inserts, recency update over all entries.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per item: s_tuser is the request type
//   (lookup or insert), s_tdata holds key and payload. m_ channel returns
//   one result per request: hit and evicted flags in m_tuser, payload and
//   evicted key in m_tdata. cfg_wr_en/cfg_wr_data write the capacity
//   register; write it only while no request is in flight.
//   An insert runs two passes from accept to result: one pass reads every tag
//   to find the key, a free slot and the oldest entry, a second pass
//   rewrites every recency rank and evicts, both at one entry per cycle
//   through the RAM read port, then writes the slot. Lookup hits skip the
//   slot write, misses skip the second pass.
//   One request is in work at a time; s_tready is high only between requests.
//   The result sits in an output register, so a new request is taken while
//   a finished result waits; a stalled receiver holds the next result in
//   the done state until the output register frees.
//   Reset clears all valid bits, the occupancy and sets capacity to 128;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_keyed_cache (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key[63:0], payload[95:64]
    input  logic         s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // payload_out[31:0], evicted_key[95:32]
    output logic [1:0]   m_tuser    // hit[0], evicted[1]
);

    localparam int IDX_W = lkc_pkg::IDX_W;
    localparam int CNT_W = lkc_pkg::CNT_W;
    localparam int KB    = lkc_pkg::KEY_BITS;
    localparam int PW    = lkc_pkg::PAYLOAD_W;

    lkc_pkg::state_t    state_reg, state_next;
    lkc_pkg::upd_mode_t mode_reg, mode_next;

    logic [lkc_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0]          occ_reg, occ_next;
    logic [lkc_pkg::ENTRIES-1:0] valid_reg, valid_next;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    logic             req_reg, req_next;
    logic [KB-1:0]    key_reg, key_next;
    logic [PW-1:0]    pl_reg, pl_next;

    logic             found_reg, found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] hit_rank_reg, hit_rank_next;
    logic [PW-1:0]    hit_data_reg, hit_data_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] lru_idx_reg, lru_idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             ev_reg, ev_next;
    logic [KB-1:0]    evkey_reg, evkey_next;

    logic             out_vld_reg, out_vld_next;
    logic             out_hit_reg, out_hit_next;
    logic             out_ev_reg, out_ev_next;
    logic [PW-1:0]    out_pl_reg, out_pl_next;
    logic [KB-1:0]    out_evkey_reg, out_evkey_next;

    logic [IDX_W-1:0] rd_addr;
    logic [KB-1:0]    tag_rd;
    logic [PW-1:0]    data_rd;
    logic [IDX_W-1:0] rank_rd;
    logic             wr_en;
    logic             rank_we;
    logic [IDX_W-1:0] rank_waddr;
    logic [IDX_W-1:0] rank_wdata;

    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] occ_inc;
    logic             pass_done;

    lkc_pkg::ent_in_t  ent;
    lkc_pkg::ent_ctl_t ctl;
    lkc_pkg::ent_res_t res;

    lkc_ram #(.WIDTH(KB), .DEPTH(lkc_pkg::ENTRIES)) u_tag_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (tag_rd)
    );

    lkc_ram #(.WIDTH(PW), .DEPTH(lkc_pkg::ENTRIES)) u_data_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (slot_reg),
        .wdata (pl_reg),
        .raddr (rd_addr),
        .rdata (data_rd)
    );

    lkc_ram #(.WIDTH(IDX_W), .DEPTH(lkc_pkg::ENTRIES)) u_rank_ram (
        .aclk  (aclk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rd_addr),
        .rdata (rank_rd)
    );

    lkc_entry_unit u_unit (
        .ent (ent),
        .ctl (ctl),
        .res (res)
    );

    assign cap_eff   = lkc_pkg::eff_cap(cap_reg);
    assign occ_inc   = (occ_reg == CNT_W'(lkc_pkg::ENTRIES)) ? occ_reg : occ_reg + 1'b1;
    assign pass_done = (idx_reg == CNT_W'(lkc_pkg::ENTRIES)) && !pend_reg;
    assign rd_addr   = idx_reg[IDX_W-1:0];

    assign ent.valid = valid_reg[pend_idx_reg];
    assign ent.tag   = tag_rd;
    assign ent.rank  = rank_rd;
    assign ent.idx   = pend_idx_reg;

    assign ctl.mode     = mode_reg;
    assign ctl.evict_en = (state_reg == lkc_pkg::ST_UPDATE) && (req_reg == lkc_pkg::REQ_INSERT);
    assign ctl.hit_idx  = hit_idx_reg;
    assign ctl.hit_rank = hit_rank_reg;
    assign ctl.cap      = cap_eff;
    assign ctl.key      = key_reg;

    assign s_tready = (state_reg == lkc_pkg::ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = {out_ev_reg, out_hit_reg};
    assign m_tdata  = {lkc_pkg::KEY_W'(out_evkey_reg), out_pl_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lkc_pkg::ST_IDLE;
            cap_reg     <= lkc_pkg::CAP_RESET;
            occ_reg     <= '0;
            valid_reg   <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            occ_reg     <= occ_next;
            valid_reg   <= valid_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        req_reg        <= req_next;
        key_reg        <= key_next;
        pl_reg         <= pl_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        hit_data_reg   <= hit_data_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        lru_idx_reg    <= lru_idx_next;
        slot_reg       <= slot_next;
        ev_reg         <= ev_next;
        evkey_reg      <= evkey_next;
        out_hit_reg    <= out_hit_next;
        out_ev_reg     <= out_ev_next;
        out_pl_reg     <= out_pl_next;
        out_evkey_reg  <= out_evkey_next;
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        occ_next        = occ_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        pl_next         = pl_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_data_next   = hit_data_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        lru_idx_next    = lru_idx_reg;
        slot_next       = slot_reg;
        ev_next         = ev_reg;
        evkey_next      = evkey_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_hit_next    = out_hit_reg;
        out_ev_next     = out_ev_reg;
        out_pl_next     = out_pl_reg;
        out_evkey_next  = out_evkey_reg;
        wr_en           = 1'b0;
        rank_we         = 1'b0;
        rank_waddr      = pend_idx_reg;
        rank_wdata      = res.new_rank[IDX_W-1:0];

        case (state_reg)
            lkc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    req_next        = s_tuser;
                    key_next        = s_tdata[KB-1:0];
                    pl_next         = s_tdata[64 +: PW];
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    ev_next         = 1'b0;
                    evkey_next      = '0;
                    state_next      = lkc_pkg::ST_SCAN;
                end
            end

            lkc_pkg::ST_SCAN: begin
                if (idx_reg != CNT_W'(lkc_pkg::ENTRIES)) begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (res.match && !found_reg) begin
                        found_next    = 1'b1;
                        hit_idx_next  = pend_idx_reg;
                        hit_rank_next = rank_rd;
                        hit_data_next = data_rd;
                    end
                    if (!ent.valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                    if (res.oldest) begin
                        lru_idx_next = pend_idx_reg;
                    end
                end
                if (pass_done) begin
                    idx_next = '0;
                    if (req_reg == lkc_pkg::REQ_LOOKUP && !found_reg) begin
                        state_next = lkc_pkg::ST_DONE;
                    end else begin
                        mode_next  = found_reg ? lkc_pkg::UPD_TOUCH : lkc_pkg::UPD_AGE;
                        // a full store reuses the slot of its oldest entry
                        slot_next  = found_reg ? hit_idx_reg :
                                     (free_found_reg ? free_idx_reg : lru_idx_reg);
                        state_next = lkc_pkg::ST_UPDATE;
                    end
                end
            end

            lkc_pkg::ST_UPDATE: begin
                if (idx_reg != CNT_W'(lkc_pkg::ENTRIES)) begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                if (pend_reg && ent.valid) begin
                    if (res.evict) begin
                        valid_next[pend_idx_reg] = 1'b0;
                    end else begin
                        rank_we = 1'b1;
                    end
                    if (res.evkey_take) begin
                        ev_next    = 1'b1;
                        evkey_next = tag_rd;
                    end
                end
                if (pass_done) begin
                    state_next = (req_reg == lkc_pkg::REQ_INSERT) ? lkc_pkg::ST_WRITE
                                                                   : lkc_pkg::ST_DONE;
                end
            end

            lkc_pkg::ST_WRITE: begin
                wr_en                = 1'b1;
                rank_we              = 1'b1;
                rank_waddr           = slot_reg;
                rank_wdata           = '0;
                valid_next[slot_reg] = 1'b1;
                if (found_reg) begin
                    occ_next = (occ_reg > cap_eff) ? cap_eff : occ_reg;
                end else begin
                    occ_next = (occ_inc > cap_eff) ? cap_eff : occ_inc;
                end
                state_next = lkc_pkg::ST_DONE;
            end

            lkc_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!out_vld_reg || m_tready) begin
                    out_vld_next   = 1'b1;
                    out_hit_next   = found_reg;
                    out_pl_next    = (found_reg && req_reg == lkc_pkg::REQ_LOOKUP)
                                     ? hit_data_reg : '0;
                    out_ev_next    = ev_reg;
                    out_evkey_next = evkey_reg;
                    state_next     = lkc_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lkc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lkc_checker.sv =====
// ----------------------------------------------------------------------------
// lkc_checker: port-level assertions for the keyed LRU cache
// Watches the top level's channels and is bound to every instance.
// ----------------------------------------------------------------------------
module lkc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time: accepting an item closes the input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    a_evkey_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[95:32] == 64'd0)
        else $error("evicted key set without eviction");

    a_payload_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31:0] != 32'd0) |-> m_tuser[0])
        else $error("payload returned without hit");

endmodule

bind lru_keyed_cache lkc_checker u_lkc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/lru_keyed_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_cache_tb: self-checking bench for the keyed LRU cache
// Drives lookups and inserts on the request stream, predicts each result
// with a behavioral LRU model of its own, and compares every result item
// field by field in arrival order. Capacity is changed between phases while
// the cache is idle. Both streams idle at random, the receiver also holds
// off for a long stretch so the cache backs up into its request port.
// ----------------------------------------------------------------------------
module lru_keyed_cache_tb;

    localparam int CLK_HALF    = 6;
    localparam int HOLD_CYCLES = 3000;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int END_TAIL    = 300;
    localparam logic [lkc_pkg::KEY_W-1:0] KEY_MASK =
        {lkc_pkg::KEY_W{1'b1}} >> (lkc_pkg::KEY_W - lkc_pkg::KEY_BITS);

    typedef struct packed {
        logic                          hit;
        logic [lkc_pkg::PAYLOAD_W-1:0] payload_out;
        logic                          evicted;
        logic [lkc_pkg::KEY_W-1:0]     evicted_key;
    } cache_result_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [7:0]   cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata     = '0;   // key[63:0], payload[95:64]
    logic         s_tuser     = 1'b0; // req_type
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [95:0]  m_tdata;            // payload_out[31:0], evicted_key[95:32]
    logic [1:0]   m_tuser;            // hit[0], evicted[1]

    // Cache model state
    logic [lkc_pkg::KEY_W-1:0]     c_tag   [lkc_pkg::ENTRIES];
    logic [lkc_pkg::PAYLOAD_W-1:0] c_data  [lkc_pkg::ENTRIES];
    bit                            c_valid [lkc_pkg::ENTRIES];
    int unsigned                   c_rank  [lkc_pkg::ENTRIES];
    int unsigned                   c_occ;
    logic [lkc_pkg::CAP_W-1:0]     c_cap;

    cache_result_t expected_results[$];
    cache_result_t got_result;
    cache_result_t want_result;

    int  fail_count    = 0;
    int  cycle_count   = 0;
    bit  idle_on       = 1'b1;
    int  rx_wait       = 0;
    int  hold_requests = 0;
    int  holds_served  = 0;

    lru_keyed_cache u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // LRU model
    // ------------------------------------------------------------------
    function automatic void cache_reset();
        for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
            c_tag[i]   = '0;
            c_data[i]  = '0;
            c_valid[i] = 1'b0;
            c_rank[i]  = 0;
        end
        c_occ = 0;
        c_cap = lkc_pkg::CAP_RESET;
    endfunction

    // Move entry to the front; younger entries age by one
    function automatic void cache_touch(int slot);
        int unsigned r;
        r = c_rank[slot];
        for (int i = 0; i < lkc_pkg::ENTRIES; i++)
            if (c_valid[i] && c_rank[i] < r) c_rank[i]++;
        c_rank[slot] = 0;
    endfunction

    function automatic logic [lkc_pkg::KEY_W-1:0] cache_evict_oldest();
        logic [lkc_pkg::KEY_W-1:0] k;
        bit                        found;
        k     = '0;
        found = 1'b0;
        for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
            if (!found && c_valid[i] && c_rank[i] == c_occ - 1) begin
                k          = c_tag[i];
                c_valid[i] = 1'b0;
                c_rank[i]  = 0;
                found      = 1'b1;
            end
        end
        c_occ--;
        return k;
    endfunction

    function automatic cache_result_t cache_access(logic req,
                                                   logic [lkc_pkg::KEY_W-1:0] key_in,
                                                   logic [lkc_pkg::PAYLOAD_W-1:0] pay);
        cache_result_t             res;
        logic [lkc_pkg::KEY_W-1:0] k;
        int                        hit_slot;
        int                        free_slot;
        int unsigned               lim;
        res       = '0;
        k         = key_in & KEY_MASK;
        hit_slot  = -1;
        free_slot = -1;
        for (int i = 0; i < lkc_pkg::ENTRIES; i++)
            if (hit_slot < 0 && c_valid[i] && c_tag[i] == k) hit_slot = i;

        if (req == lkc_pkg::REQ_LOOKUP) begin
            if (hit_slot >= 0) begin
                res.hit         = 1'b1;
                res.payload_out = c_data[hit_slot];
                cache_touch(hit_slot);
            end
        end else begin
            if (hit_slot >= 0) begin
                res.hit          = 1'b1;
                c_data[hit_slot] = pay;
                cache_touch(hit_slot);
            end else begin
                // Full store: drop the oldest first to free its slot
                if (c_occ >= lkc_pkg::ENTRIES) begin
                    res.evicted_key = cache_evict_oldest();
                    res.evicted     = 1'b1;
                end
                for (int i = 0; i < lkc_pkg::ENTRIES; i++)
                    if (free_slot < 0 && !c_valid[i]) free_slot = i;
                if (free_slot >= 0) begin
                    for (int j = 0; j < lkc_pkg::ENTRIES; j++)
                        if (c_valid[j]) c_rank[j]++;
                    c_valid[free_slot] = 1'b1;
                    c_tag[free_slot]   = k;
                    c_data[free_slot]  = pay;
                    c_rank[free_slot]  = 0;
                    c_occ++;
                end
            end
            lim = (c_cap == 0) ? 1 :
                  ((c_cap > lkc_pkg::ENTRIES) ? lkc_pkg::ENTRIES : c_cap);
            while (c_occ > lim) begin
                res.evicted_key = cache_evict_oldest();
                res.evicted     = 1'b1;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [lkc_pkg::KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [lkc_pkg::PAYLOAD_W-1:0] rand_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(logic req, logic [lkc_pkg::KEY_W-1:0] k,
                                logic [lkc_pkg::PAYLOAD_W-1:0] pay);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {pay, k};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(cache_access(req, k, pay));
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic wait_idle(int tail);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [lkc_pkg::CAP_W-1:0] v);
        wait_idle(8);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        c_cap = v;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [lkc_pkg::KEY_W-1:0] k_zero;
        logic [lkc_pkg::KEY_W-1:0] k_ones;
        logic [lkc_pkg::KEY_W-1:0] k_five;
        logic [lkc_pkg::KEY_W-1:0] k_aaaa;
        k_zero = '0;
        k_ones = '1;
        k_five = {16{4'h5}};
        k_aaaa = {16{4'hA}};
        send_request(lkc_pkg::REQ_LOOKUP, k_zero, 32'h1234_5678);   // miss on empty cache
        send_request(lkc_pkg::REQ_INSERT, k_zero, 32'hFFFF_FFFF);
        send_request(lkc_pkg::REQ_LOOKUP, k_zero, 32'h0);
        send_request(lkc_pkg::REQ_INSERT, k_ones, 32'h0);
        send_request(lkc_pkg::REQ_LOOKUP, k_ones, 32'hFFFF_FFFF);
        send_request(lkc_pkg::REQ_INSERT, k_zero, 32'hA5A5_A5A5);   // update in place
        send_request(lkc_pkg::REQ_LOOKUP, k_zero, 32'h0);
        send_request(lkc_pkg::REQ_INSERT, k_five, 32'h5A5A_5A5A);
        send_request(lkc_pkg::REQ_LOOKUP, k_aaaa, 32'h0);
        // Lower capacity below occupancy: lookups leave it, insert trims it
        set_capacity(8'd1);
        send_request(lkc_pkg::REQ_LOOKUP, k_zero, 32'h0);
        send_request(lkc_pkg::REQ_INSERT, k_aaaa, 32'hDEAD_BEEF);
        send_request(lkc_pkg::REQ_LOOKUP, k_five, 32'h0);
        // Zero capacity acts as one
        set_capacity(8'd0);
        send_request(lkc_pkg::REQ_INSERT, 64'd1, 32'h1);
        send_request(lkc_pkg::REQ_INSERT, 64'd2, 32'h2);
        send_request(lkc_pkg::REQ_LOOKUP, 64'd1, 32'h0);
        // Capacity above the store size acts as the store size
        set_capacity(8'd255);
        send_request(lkc_pkg::REQ_INSERT, 64'd3, 32'h3);
        send_request(lkc_pkg::REQ_INSERT, 64'd4, 32'h4);
        send_request(lkc_pkg::REQ_LOOKUP, 64'd2, 32'h0);
        set_capacity(8'd2);
        send_request(lkc_pkg::REQ_INSERT, 64'd5, 32'h5);
        send_request(lkc_pkg::REQ_LOOKUP, 64'd2, 32'h0);
        send_request(lkc_pkg::REQ_LOOKUP, 64'd5, 32'h0);
    endtask

    task automatic test_capacity_drop();
        logic [lkc_pkg::KEY_W-1:0] keys [10];
        set_capacity(8'd128);
        foreach (keys[i]) begin
            keys[i] = rand_key();
            send_request(lkc_pkg::REQ_INSERT, keys[i], rand_payload());
        end
        set_capacity(8'd4);
        send_request(lkc_pkg::REQ_LOOKUP, keys[9], '0);
        send_request(lkc_pkg::REQ_LOOKUP, keys[0], '0);
        send_request(lkc_pkg::REQ_LOOKUP, keys[5], '0);
        send_request(lkc_pkg::REQ_INSERT, keys[2], rand_payload());   // hit, then trim to four
        send_request(lkc_pkg::REQ_LOOKUP, keys[0], '0);
        send_request(lkc_pkg::REQ_LOOKUP, keys[1], '0);
    endtask

    // Fill all slots, then keep inserting new keys into the full store
    task automatic test_fill_store();
        logic [lkc_pkg::KEY_W-1:0] keys [$];
        set_capacity(8'd128);
        for (int n = 0; n < lkc_pkg::ENTRIES + 6; n++) begin
            keys.push_back(rand_key());
            send_request(lkc_pkg::REQ_INSERT, keys[n], rand_payload());
        end
        for (int n = 0; n < 10; n++)
            send_request(lkc_pkg::REQ_LOOKUP, keys[$urandom_range(0, keys.size() - 1)], '0);
    endtask

    task automatic test_backpressure();
        hold_requests = hold_requests + 1;
        for (int n = 0; n < 6; n++)
            send_request($urandom_range(0, 1) ? lkc_pkg::REQ_INSERT : lkc_pkg::REQ_LOOKUP,
                         rand_key(), rand_payload());
        wait_idle(8);
        for (int n = 0; n < 4; n++)
            send_request(lkc_pkg::REQ_LOOKUP, rand_key(), rand_payload());
    endtask

    task automatic test_random();
        logic [lkc_pkg::CAP_W-1:0] caps [10] = '{8'd1, 8'd2, 8'd5, 8'd16, 8'd64,
                                                 8'd127, 8'd128, 8'd0, 8'd200, 8'd255};
        logic [lkc_pkg::KEY_W-1:0] pool [$];
        logic [lkc_pkg::KEY_W-1:0] k;
        int                        pool_size;
        foreach (caps[p]) begin
            set_capacity(caps[p]);
            pool_size = 3 + ((caps[p] > 140) ? 140 : caps[p]) * 3 / 2;
            pool.delete();
            repeat (pool_size) pool.push_back(rand_key());
            pool.push_back('0);
            pool.push_back('1);
            for (int n = 0; n < 170; n++) begin
                // every third stretch of items runs with no idling
                idle_on = (n % 60) >= 20;
                if ($urandom_range(0, 9) == 0)
                    k = rand_key();
                else
                    k = pool[$urandom_range(0, pool.size() - 1)];
                send_request($urandom_range(0, 1) ? lkc_pkg::REQ_INSERT : lkc_pkg::REQ_LOOKUP,
                             k, rand_payload());
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_result.hit         = m_tuser[0];
                got_result.evicted     = m_tuser[1];
                got_result.payload_out = m_tdata[31:0];
                got_result.evicted_key = m_tdata[95:32];
                if (expected_results.size() == 0) begin
                    $error("result item with no request pending");
                    fail_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.hit !== want_result.hit) begin
                        $error("hit: expected %0d, got %0d",
                               want_result.hit, got_result.hit);
                        fail_count++;
                    end
                    if (got_result.payload_out !== want_result.payload_out) begin
                        $error("payload_out: expected %h, got %h",
                               want_result.payload_out, got_result.payload_out);
                        fail_count++;
                    end
                    if (got_result.evicted !== want_result.evicted) begin
                        $error("evicted: expected %0d, got %0d",
                               want_result.evicted, got_result.evicted);
                        fail_count++;
                    end
                    if (got_result.evicted_key !== want_result.evicted_key) begin
                        $error("evicted_key: expected %h, got %h",
                               want_result.evicted_key, got_result.evicted_key);
                        fail_count++;
                    end
                end
                rx_wait = idle_on ? $urandom_range(0, 15) : 0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            // Long hold-off so the cache backs up into its request port
            if (holds_served != hold_requests) begin
                rx_wait      = HOLD_CYCLES;
                holds_served = holds_served + 1;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("lru_keyed_cache_tb NOT OK");
        $finish;
    end

    initial begin
        cache_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_capacity_drop();
        test_fill_store();
        test_backpressure();
        test_random();
        wait_idle(END_TAIL);
        if (fail_count == 0) begin
            $display("lru_keyed_cache_tb OK");
        end else begin
            $display("lru_keyed_cache_tb NOT OK");
        end
        $finish;
    end

endmodule
